/* hdl/frc_pkg.sv */
// ----------------------------------------------------------------------------
// frc_pkg: shared types and constants of the frame receiver
// Field widths, parser phases, emitter states and the structs that pass
// between the parser, the descriptor queue and the emitter.
// ----------------------------------------------------------------------------
package frc_pkg;

  // Largest payload a frame may carry
  localparam int MaxPayload = 32;
  localparam int IdxW       = $clog2(MaxPayload);
  localparam int LenW       = 6;
  localparam int ByteW      = 8;
  localparam int BankW      = 1;
  localparam int AddrW      = BankW + IdxW;
  localparam int MemDepth   = 2 * MaxPayload;

  localparam logic [ByteW-1:0] MaxLenByte   = ByteW'(MaxPayload);
  localparam logic [ByteW-1:0] MarkerReset  = 8'd85;

  // Descriptor queue geometry
  localparam int FifoDepth = 2;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_SRC,
    PH_DST,
    PH_CMD,
    PH_LEN,
    PH_CHK,
    PH_PAY
  } phase_e;

  typedef enum logic [1:0] {
    EM_IDLE,
    EM_FETCH,
    EM_SHOW
  } emit_state_e;

  // One checked frame waiting to be emitted
  typedef struct packed {
    logic [ByteW-1:0] src;
    logic [ByteW-1:0] dst;
    logic [ByteW-1:0] cmd;
    logic [LenW-1:0]  len;
    logic [BankW-1:0] bank;
  } desc_t;

  // Payload store write port
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [ByteW-1:0] data;
  } wr_t;

  // Bank release from the emitter
  typedef struct packed {
    logic             en;
    logic [BankW-1:0] bank;
  } rel_t;

endpackage

/* hdl/frc_ifs.sv */
// ----------------------------------------------------------------------------
// frc_ifs: channel interfaces of the frame receiver
// Byte input channel, start marker write channel and result channel.
// ----------------------------------------------------------------------------
interface frc_byte_if;
  logic                    valid;
  logic                    ready;
  logic [frc_pkg::ByteW-1:0] rx_value;

  modport source (output valid, output rx_value, input ready);
  modport sink   (input valid, input rx_value, output ready);
endinterface

interface frc_cfg_if;
  logic                    valid;
  logic                    ready;
  logic [frc_pkg::ByteW-1:0] start_marker;

  modport source (output valid, output start_marker, input ready);
  modport sink   (input valid, input start_marker, output ready);
endinterface

interface frc_result_if;
  logic                      valid;
  logic                      ready;
  logic [frc_pkg::ByteW-1:0] source_addr;
  logic [frc_pkg::ByteW-1:0] dest_addr;
  logic [frc_pkg::ByteW-1:0] command;
  logic [frc_pkg::LenW-1:0]  payload_length;
  logic [frc_pkg::ByteW-1:0] payload_value;
  logic [frc_pkg::IdxW-1:0]  payload_index;
  logic                      payload_present;
  logic                      frame_last;

  modport source (output valid, output source_addr, output dest_addr, output command,
                  output payload_length, output payload_value, output payload_index,
                  output payload_present, output frame_last, input ready);
  modport sink   (input valid, input source_addr, input dest_addr, input command,
                  input payload_length, input payload_value, input payload_index,
                  input payload_present, input frame_last, output ready);
endinterface

/* hdl/frc_parser.sv */
// ----------------------------------------------------------------------------
// frc_parser: front end of the frame receiver
// Hunts for the start marker, captures the header, writes the payload into
// the free bank of the store and queues a descriptor for each good frame.
// ----------------------------------------------------------------------------
module frc_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  frc_byte_if.sink            rx_i,
  frc_cfg_if.sink             cfg_i,
  output logic                push_valid_o,
  output frc_pkg::desc_t      push_data_o,
  input  logic                push_ready_i,
  output frc_pkg::wr_t        wr_o,
  input  frc_pkg::rel_t       rel_i
);

  frc_pkg::phase_e                phase_q, phase_d;
  logic [frc_pkg::ByteW-1:0]      marker_q;
  logic [frc_pkg::ByteW-1:0]      src_q, dst_q, cmd_q, chk_q, sum_q;
  logic [frc_pkg::LenW-1:0]       len_q, cnt_q;
  logic [frc_pkg::BankW-1:0]      bank_q;
  logic [1:0]                     busy_q, busy_d;

  logic                           accept;
  logic [frc_pkg::ByteW-1:0]      b;
  logic [frc_pkg::ByteW-1:0]      sum_add;
  logic [frc_pkg::LenW-1:0]       cnt_inc;
  logic                           pay_done;
  logic                           push;

  assign accept  = rx_i.valid && rx_i.ready;
  assign b       = rx_i.rx_value;
  assign sum_add = sum_q + b;
  assign cnt_inc = cnt_q + frc_pkg::LenW'(1);
  assign pay_done = (cnt_inc >= len_q);

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (accept) begin
      unique case (phase_q)
        frc_pkg::PH_IDLE: phase_d = (b == marker_q) ? frc_pkg::PH_SRC : frc_pkg::PH_IDLE;
        frc_pkg::PH_SRC:  phase_d = frc_pkg::PH_DST;
        frc_pkg::PH_DST:  phase_d = frc_pkg::PH_CMD;
        frc_pkg::PH_CMD:  phase_d = frc_pkg::PH_LEN;
        frc_pkg::PH_LEN:  phase_d = (b > frc_pkg::MaxLenByte) ? frc_pkg::PH_IDLE
                                                              : frc_pkg::PH_CHK;
        frc_pkg::PH_CHK:  phase_d = (len_q == '0) ? frc_pkg::PH_IDLE : frc_pkg::PH_PAY;
        frc_pkg::PH_PAY:  phase_d = pay_done ? frc_pkg::PH_IDLE : frc_pkg::PH_PAY;
        default:          phase_d = frc_pkg::PH_IDLE;
      endcase
    end
  end

  // Handshakes, store writes and descriptor push
  always_comb begin
    cfg_i.ready = 1'b1;
    if (phase_q == frc_pkg::PH_CHK || phase_q == frc_pkg::PH_PAY) begin
      rx_i.ready = !busy_q[bank_q] && push_ready_i;
    end else begin
      rx_i.ready = 1'b1;
    end
    push = accept &&
           ((phase_q == frc_pkg::PH_CHK && len_q == '0 && sum_q == b) ||
            (phase_q == frc_pkg::PH_PAY && pay_done && sum_add == chk_q));
    push_valid_o     = push;
    push_data_o.src  = src_q;
    push_data_o.dst  = dst_q;
    push_data_o.cmd  = cmd_q;
    push_data_o.len  = len_q;
    push_data_o.bank = bank_q;
    wr_o.en   = accept && (phase_q == frc_pkg::PH_PAY);
    wr_o.addr = {bank_q, cnt_q[frc_pkg::IdxW-1:0]};
    wr_o.data = b;
  end

  // Bank ownership: set on push, clear on release
  always_comb begin
    busy_d = busy_q;
    if (rel_i.en) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (push) begin
      busy_d[bank_q] = 1'b1;
    end
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= frc_pkg::PH_IDLE;
      marker_q <= frc_pkg::MarkerReset;
      bank_q   <= '0;
      busy_q   <= '0;
      sum_q    <= '0;
      cnt_q    <= '0;
      len_q    <= '0;
    end else begin
      phase_q <= phase_d;
      busy_q  <= busy_d;
      if (cfg_i.valid) begin
        marker_q <= cfg_i.start_marker;
      end
      if (push) begin
        bank_q <= ~bank_q;
      end
      if (accept) begin
        unique case (phase_q)
          frc_pkg::PH_IDLE: begin
            if (b == marker_q) begin
              sum_q <= '0;
              cnt_q <= '0;
              len_q <= '0;
            end
          end
          frc_pkg::PH_SRC, frc_pkg::PH_DST, frc_pkg::PH_CMD: sum_q <= sum_add;
          frc_pkg::PH_LEN: begin
            if (b <= frc_pkg::MaxLenByte) begin
              len_q <= b[frc_pkg::LenW-1:0];
              sum_q <= sum_add;
            end
          end
          frc_pkg::PH_CHK: cnt_q <= '0;
          frc_pkg::PH_PAY: begin
            sum_q <= sum_add;
            cnt_q <= pay_done ? '0 : cnt_inc;
          end
          default: ;
        endcase
      end
    end
  end

  // Header bytes
  always_ff @(posedge clk_i) begin
    if (accept) begin
      unique case (phase_q)
        frc_pkg::PH_SRC: src_q <= b;
        frc_pkg::PH_DST: dst_q <= b;
        frc_pkg::PH_CMD: cmd_q <= b;
        frc_pkg::PH_CHK: chk_q <= b;
        default: ;
      endcase
    end
  end

  // Never write into a bank the emitter still owns
  assert property (@(posedge clk_i) disable iff (!rst_ni) wr_o.en |-> !busy_q[bank_q])
    else $error("payload write into busy bank");

  // A release names a bank that is owned
  assert property (@(posedge clk_i) disable iff (!rst_ni) rel_i.en |-> busy_q[rel_i.bank])
    else $error("release of a free bank");

  // A pushed frame leaves its bank owned and moves writing to the other bank
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   push |=> (busy_q[$past(bank_q)] && bank_q != $past(bank_q)))
    else $error("bank handoff after push lost");

endmodule

/* hdl/frc_desc_fifo.sv */
// ----------------------------------------------------------------------------
// frc_desc_fifo: descriptor queue between parser and emitter
// Small register FIFO of frame descriptors.
// ----------------------------------------------------------------------------
module frc_desc_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  input  frc_pkg::desc_t push_data_i,
  output logic           push_ready_o,
  output logic           pop_valid_o,
  output frc_pkg::desc_t pop_data_o,
  input  logic           pop_ready_i
);

  frc_pkg::desc_t                 mem_q [frc_pkg::FifoDepth];
  logic [frc_pkg::FifoPtrW-1:0]   wptr_q, rptr_q;
  logic [frc_pkg::FifoCntW-1:0]   cnt_q;
  logic                           do_push, do_pop;

  assign push_ready_o = (cnt_q != frc_pkg::FifoCntW'(frc_pkg::FifoDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wptr_q + frc_pkg::FifoPtrW'(1);
      end
      if (do_pop) begin
        rptr_q <= rptr_q + frc_pkg::FifoPtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + frc_pkg::FifoCntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - frc_pkg::FifoCntW'(1);
      end
    end
  end

  // Store descriptors
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= push_data_i;
    end
  end

endmodule

/* hdl/frc_emitter.sv */
// ----------------------------------------------------------------------------
// frc_emitter: back end of the frame receiver
// Holds the double-banked payload store, takes one descriptor at a time and
// emits one result word per payload byte, or one without payload if empty.
// ----------------------------------------------------------------------------
module frc_emitter (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  frc_pkg::wr_t   wr_i,
  input  logic           pop_valid_i,
  input  frc_pkg::desc_t pop_data_i,
  output logic           pop_ready_o,
  output frc_pkg::rel_t  rel_o,
  frc_result_if.source   res_o
);

  logic [frc_pkg::ByteW-1:0]   mem [frc_pkg::MemDepth];
  logic [frc_pkg::ByteW-1:0]   rd_q;
  frc_pkg::emit_state_e        state_q, state_d;
  frc_pkg::desc_t              desc_q;
  logic [frc_pkg::IdxW-1:0]    idx_q;
  logic [frc_pkg::AddrW-1:0]   rd_addr;
  logic                        present;
  logic                        last;
  logic                        out_take;

  assign rd_addr  = {desc_q.bank, idx_q};
  assign present  = (desc_q.len != '0);
  assign last     = !present ||
                    ((frc_pkg::LenW'(idx_q) + frc_pkg::LenW'(1)) == desc_q.len);
  assign out_take = (state_q == frc_pkg::EM_SHOW) && res_o.ready;

  // Payload store: one write port from the parser, one registered read
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_q <= mem[rd_addr];
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      frc_pkg::EM_IDLE:  if (pop_valid_i) state_d = frc_pkg::EM_FETCH;
      frc_pkg::EM_FETCH: state_d = frc_pkg::EM_SHOW;
      frc_pkg::EM_SHOW:  if (res_o.ready) state_d = last ? frc_pkg::EM_IDLE
                                                         : frc_pkg::EM_FETCH;
      default:           state_d = frc_pkg::EM_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    pop_ready_o           = (state_q == frc_pkg::EM_IDLE);
    rel_o.en              = out_take && last;
    rel_o.bank            = desc_q.bank;
    res_o.valid           = (state_q == frc_pkg::EM_SHOW);
    res_o.source_addr     = desc_q.src;
    res_o.dest_addr       = desc_q.dst;
    res_o.command         = desc_q.cmd;
    res_o.payload_length  = desc_q.len;
    res_o.payload_value   = present ? rd_q : '0;
    res_o.payload_index   = idx_q;
    res_o.payload_present = present;
    res_o.frame_last      = last;
  end

  // State and index
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frc_pkg::EM_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (pop_valid_i && pop_ready_o) begin
        idx_q <= '0;
      end else if (out_take && !last) begin
        idx_q <= idx_q + frc_pkg::IdxW'(1);
      end
    end
  end

  // Load descriptor
  always_ff @(posedge clk_i) begin
    if (pop_valid_i && pop_ready_o) begin
      desc_q <= pop_data_i;
    end
  end

endmodule

/* hdl/frame_receiver_with_checksum_core.sv */
// ----------------------------------------------------------------------------
// frame_receiver_with_checksum_core: byte-framed receiver with checksum
// Parses marker-framed packets from a byte stream and emits checked frames.
//
// Usage:
//   rx_i  carries one link byte per word. Outside a frame every byte but the
//         start marker is dropped; then source, destination, command, length,
//         checksum and the payload follow.
//   cfg_i writes the start marker (reset value 85); always ready.
//   res_o gives one word per payload byte of a frame whose additive checksum
//         matches, or one word without payload for an empty frame.
// Throughput: rx_i takes one byte per cycle. It stalls only on checksum and
//   payload bytes while both payload banks still await emission.
// Result path: a checked frame's descriptor passes through the queue; the
//   emitter then fetches each word through the registered read of the store
//   and shows it, fetching the next only after the previous one is taken.
// Reset: asynchronous; the parser returns to hunting the marker and the
//   queue empties. The payload store is not cleared.
// A stalled res_o holds its word; the parser keeps taking bytes into the
//   other bank meanwhile.
// ----------------------------------------------------------------------------
module frame_receiver_with_checksum_core (
  input  logic         clk_i,
  input  logic         rst_ni,
  frc_byte_if.sink     rx_i,
  frc_cfg_if.sink      cfg_i,
  frc_result_if.source res_o
);

  logic           push_valid, push_ready;
  frc_pkg::desc_t push_data;
  logic           pop_valid, pop_ready;
  frc_pkg::desc_t pop_data;
  frc_pkg::wr_t   wr;
  frc_pkg::rel_t  rel;

  // Front: parse and check
  frc_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_i         (rx_i),
    .cfg_i        (cfg_i),
    .push_valid_o (push_valid),
    .push_data_o  (push_data),
    .push_ready_i (push_ready),
    .wr_o         (wr),
    .rel_i        (rel)
  );

  // Queue of checked frames
  frc_desc_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_data_i  (push_data),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_data_o   (pop_data),
    .pop_ready_i  (pop_ready)
  );

  // Back: emit results
  frc_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_i        (wr),
    .pop_valid_i (pop_valid),
    .pop_data_i  (pop_data),
    .pop_ready_o (pop_ready),
    .rel_o       (rel),
    .res_o       (res_o)
  );

endmodule

/* bench/frame_receiver_with_checksum_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_receiver_with_checksum_core_tb: self-checking bench of the receiver
// Drives link bytes, forms good, corrupt, oversize and cut frames, rewrites
// the start marker between phases and checks each result word against a
// shadow parser kept in step with the accepted bytes.
// ----------------------------------------------------------------------------
module frame_receiver_with_checksum_core_tb;

  localparam int SettleCycles = 10;
  localparam int HoldCycles   = 400;
  localparam int DrainLimit   = 20000;
  localparam int TimeoutNs    = 5_000_000;
  localparam int PhaseBytes   = 16;

  // One result word as the block shows it
  typedef struct packed {
    logic [frc_pkg::ByteW-1:0] src;
    logic [frc_pkg::ByteW-1:0] dst;
    logic [frc_pkg::ByteW-1:0] cmd;
    logic [frc_pkg::LenW-1:0]  len;
    logic [frc_pkg::ByteW-1:0] value;
    logic [frc_pkg::IdxW-1:0]  index;
    logic                      present;
    logic                      last;
  } frame_word_t;

  typedef enum logic [1:0] {
    ROW_PREDICT,
    ROW_QUIET,
    ROW_ONE
  } row_kind_e;

  typedef enum logic [2:0] {
    FR_GOOD,
    FR_BADSUM,
    FR_OVERSIZE,
    FR_CUT,
    FR_NOISE
  } frame_kind_e;

  typedef struct packed {
    logic [frc_pkg::ByteW-1:0] rx;
    row_kind_e                 kind;
    frame_word_t               word;
  } stim_row_t;

  localparam frame_word_t NoWord = '0;

  logic clk_i = 1'b0;
  logic rst_ni;

  frc_byte_if   rx_if ();
  frc_cfg_if    cfg_if ();
  frc_result_if res_if ();

  frame_receiver_with_checksum_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rx_i   (rx_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  always #5 clk_i = ~clk_i;

  // Shadow parser state
  frc_pkg::phase_e           shadow_phase  = frc_pkg::PH_IDLE;
  logic [frc_pkg::ByteW-1:0] shadow_marker = frc_pkg::MarkerReset;
  logic [frc_pkg::ByteW-1:0] shadow_src    = '0;
  logic [frc_pkg::ByteW-1:0] shadow_dst    = '0;
  logic [frc_pkg::ByteW-1:0] shadow_cmd    = '0;
  logic [frc_pkg::LenW-1:0]  shadow_len    = '0;
  logic [frc_pkg::ByteW-1:0] shadow_check  = '0;
  logic [frc_pkg::ByteW-1:0] shadow_sum    = '0;
  int                        shadow_count  = 0;
  logic [frc_pkg::ByteW-1:0] shadow_store [frc_pkg::MaxPayload];

  frame_word_t frame_words_due [$];
  stim_row_t   directed_rows [$];
  int          bytes_taken  = 0;
  int          mismatches   = 0;
  bit          sender_tight = 1'b0;
  bit          hold_request = 1'b0;

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    mismatches++;
  endtask

  // Mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 80);
  endfunction

  // Mostly small payloads, now and then the largest
  function automatic int pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, 4);
    if (r < 85) return $urandom_range(5, 15);
    if (r < 95) return $urandom_range(16, frc_pkg::MaxPayload - 1);
    return frc_pkg::MaxPayload;
  endfunction

  // Emit the words of a finished frame if its sum matches
  task automatic close_frame(ref frame_word_t words[$]);
    frame_word_t w;
    shadow_phase = frc_pkg::PH_IDLE;
    shadow_count = 0;
    if (shadow_check != shadow_sum) return;
    w.src = shadow_src;
    w.dst = shadow_dst;
    w.cmd = shadow_cmd;
    w.len = shadow_len;
    if (shadow_len == 0) begin
      w.value   = '0;
      w.index   = '0;
      w.present = 1'b0;
      w.last    = 1'b1;
      words.push_back(w);
      return;
    end
    for (int i = 0; i < shadow_len; i++) begin
      w.value   = shadow_store[i];
      w.index   = frc_pkg::IdxW'(i);
      w.present = 1'b1;
      w.last    = (i + 1 == shadow_len);
      words.push_back(w);
    end
  endtask

  // Advance the shadow parser by one link byte
  task automatic parse_link_byte(input logic [frc_pkg::ByteW-1:0] b,
                                 ref frame_word_t words[$]);
    case (shadow_phase)
      frc_pkg::PH_SRC: begin
        shadow_src   = b;
        shadow_sum  += b;
        shadow_phase = frc_pkg::PH_DST;
      end
      frc_pkg::PH_DST: begin
        shadow_dst   = b;
        shadow_sum  += b;
        shadow_phase = frc_pkg::PH_CMD;
      end
      frc_pkg::PH_CMD: begin
        shadow_cmd   = b;
        shadow_sum  += b;
        shadow_phase = frc_pkg::PH_LEN;
      end
      frc_pkg::PH_LEN: begin
        if (b > frc_pkg::MaxLenByte) begin
          shadow_phase = frc_pkg::PH_IDLE;
          shadow_count = 0;
        end else begin
          shadow_len   = b[frc_pkg::LenW-1:0];
          shadow_sum  += b;
          shadow_phase = frc_pkg::PH_CHK;
        end
      end
      frc_pkg::PH_CHK: begin
        shadow_check = b;
        if (shadow_len == 0) begin
          close_frame(words);
        end else begin
          shadow_count = 0;
          shadow_phase = frc_pkg::PH_PAY;
        end
      end
      frc_pkg::PH_PAY: begin
        if (shadow_count < frc_pkg::MaxPayload) shadow_store[shadow_count] = b;
        shadow_sum += b;
        shadow_count++;
        if (shadow_count >= shadow_len) close_frame(words);
      end
      default: begin
        if (b == shadow_marker) begin
          shadow_phase = frc_pkg::PH_SRC;
          shadow_sum   = '0;
          shadow_count = 0;
          shadow_src   = '0;
          shadow_dst   = '0;
          shadow_cmd   = '0;
          shadow_len   = '0;
          shadow_check = '0;
        end else begin
          shadow_phase = frc_pkg::PH_IDLE;
        end
      end
    endcase
  endtask

  // Offer one byte, wait for the handshake, then book what it causes
  task automatic send_byte(input logic [frc_pkg::ByteW-1:0] b, input row_kind_e kind,
                           input frame_word_t word);
    frame_word_t fresh [$];
    int gap;
    gap = sender_tight ? 0 : pick_gap();
    if (gap > 0) begin
      @(negedge clk_i);
      rx_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    rx_if.valid    <= 1'b1;
    rx_if.rx_value <= b;
    do @(posedge clk_i); while (!rx_if.ready);
    bytes_taken++;
    parse_link_byte(b, fresh);
    case (kind)
      ROW_PREDICT: foreach (fresh[i]) frame_words_due.push_back(fresh[i]);
      ROW_ONE:     frame_words_due.push_back(word);
      default:     ;
    endcase
  endtask

  task automatic add_row(input logic [frc_pkg::ByteW-1:0] b, input row_kind_e kind,
                         input frame_word_t word);
    stim_row_t row;
    row.rx   = b;
    row.kind = kind;
    row.word = word;
    directed_rows.push_back(row);
  endtask

  // Feed bytes until the parser is back to hunting the marker
  task automatic flush_parser();
    while (shadow_phase != frc_pkg::PH_IDLE) send_byte(8'($urandom), ROW_PREDICT, NoWord);
  endtask

  task automatic send_frame(input frame_kind_e kind, input int len);
    logic [frc_pkg::ByteW-1:0] head [3];
    logic [frc_pkg::ByteW-1:0] body [$];
    logic [frc_pkg::ByteW-1:0] sum;
    int upto;
    if (kind == FR_NOISE) begin
      repeat (len) send_byte(8'($urandom), ROW_PREDICT, NoWord);
      return;
    end
    sum = 8'(len);
    foreach (head[i]) begin
      head[i] = 8'($urandom);
      sum += head[i];
    end
    repeat (len) begin
      body.push_back(8'($urandom));
      sum += body[$];
    end
    if (kind == FR_BADSUM) sum ^= 8'($urandom_range(1, 255));
    send_byte(shadow_marker, ROW_PREDICT, NoWord);
    foreach (head[i]) send_byte(head[i], ROW_PREDICT, NoWord);
    if (kind == FR_OVERSIZE) begin
      send_byte(8'($urandom_range(frc_pkg::MaxPayload + 1, 255)), ROW_PREDICT, NoWord);
      return;
    end
    send_byte(8'(len), ROW_PREDICT, NoWord);
    send_byte(sum, ROW_PREDICT, NoWord);
    upto = (kind == FR_CUT) ? $urandom_range(0, len - 1) : len;
    for (int i = 0; i < upto; i++) send_byte(body[i], ROW_PREDICT, NoWord);
  endtask

  task automatic random_traffic(input int goal);
    int r;
    int len;
    while (bytes_taken < goal) begin
      if ($urandom_range(0, 9) < 8) flush_parser();
      sender_tight = ($urandom_range(0, 3) == 0);
      r   = $urandom_range(0, 99);
      len = pick_len();
      if (r < 65)      send_frame(FR_GOOD, len);
      else if (r < 75) send_frame(FR_BADSUM, len);
      else if (r < 82) send_frame(FR_OVERSIZE, len);
      else if (r < 90) send_frame(FR_CUT, (len == 0) ? 1 : len);
      else             send_frame(FR_NOISE, $urandom_range(1, 6));
    end
    sender_tight = 1'b0;
  endtask

  // Bring the block to rest before touching the marker
  task automatic settle();
    flush_parser();
    @(negedge clk_i);
    rx_if.valid <= 1'b0;
    while (frame_words_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_marker(input logic [frc_pkg::ByteW-1:0] m);
    @(negedge clk_i);
    cfg_if.valid        <= 1'b1;
    cfg_if.start_marker <= m;
    do @(posedge clk_i); while (!cfg_if.ready);
    shadow_marker = m;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic check_word(input frame_word_t got, input frame_word_t want);
    if (got.src !== want.src)
      report_mismatch($sformatf("source_addr %0h, want %0h", got.src, want.src));
    if (got.dst !== want.dst)
      report_mismatch($sformatf("dest_addr %0h, want %0h", got.dst, want.dst));
    if (got.cmd !== want.cmd)
      report_mismatch($sformatf("command %0h, want %0h", got.cmd, want.cmd));
    if (got.len !== want.len)
      report_mismatch($sformatf("payload_length %0d, want %0d", got.len, want.len));
    if (got.value !== want.value)
      report_mismatch($sformatf("payload_value %0h, want %0h", got.value, want.value));
    if (got.index !== want.index)
      report_mismatch($sformatf("payload_index %0d, want %0d", got.index, want.index));
    if (got.present !== want.present)
      report_mismatch($sformatf("payload_present %0b, want %0b", got.present, want.present));
    if (got.last !== want.last)
      report_mismatch($sformatf("frame_last %0b, want %0b", got.last, want.last));
  endtask

  // Compare each taken result word with the oldest one due
  always @(posedge clk_i) begin : result_check
    frame_word_t got;
    if (rst_ni === 1'b1 && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
      got.src     = res_if.source_addr;
      got.dst     = res_if.dest_addr;
      got.cmd     = res_if.command;
      got.len     = res_if.payload_length;
      got.value   = res_if.payload_value;
      got.index   = res_if.payload_index;
      got.present = res_if.payload_present;
      got.last    = res_if.frame_last;
      if (frame_words_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word %0h", got));
      end else begin
        check_word(got, frame_words_due.pop_front());
      end
    end
  end

  // Result side: random ready with one long hold-off on request
  initial begin : result_sink
    int run;
    int gap;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        @(negedge clk_i);
        res_if.ready <= 1'b0;
        repeat (HoldCycles - 1) @(negedge clk_i);
      end
      run = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
      @(negedge clk_i);
      res_if.ready <= 1'b1;
      repeat (run - 1) @(negedge clk_i);
      gap = pick_gap();
      if (gap > 0) begin
        @(negedge clk_i);
        res_if.ready <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
    end
  end

  initial begin : watchdog
    #(TimeoutNs);
    $display("frame_receiver_with_checksum_core regression: fail");
    $finish;
  end

  initial begin : stimulus
    logic [frc_pkg::ByteW-1:0] markers [4];
    int drain_cycles;
    rst_ni              <= 1'b0;
    rx_if.valid         <= 1'b0;
    rx_if.rx_value      <= '0;
    cfg_if.valid        <= 1'b0;
    cfg_if.start_marker <= '0;
    for (int i = 0; i < frc_pkg::MaxPayload; i++) shadow_store[i] = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed rows: idle bytes, empty frames, oversize length, bad sum,
    // marker value inside a frame
    add_row(8'h00, ROW_QUIET, NoWord);
    add_row(8'hFF, ROW_QUIET, NoWord);
    add_row(frc_pkg::MarkerReset, ROW_PREDICT, NoWord);
    add_row(8'hFF, ROW_PREDICT, NoWord);
    add_row(8'h01, ROW_PREDICT, NoWord);
    add_row(8'h00, ROW_PREDICT, NoWord);
    add_row(8'h00, ROW_PREDICT, NoWord);
    add_row(8'h00, ROW_ONE, {8'hFF, 8'h01, 8'h00, 6'd0, 8'h00, 5'd0, 1'b0, 1'b1});
    add_row(frc_pkg::MarkerReset, ROW_PREDICT, NoWord);
    add_row(frc_pkg::MarkerReset, ROW_PREDICT, NoWord);
    add_row(8'hAA, ROW_PREDICT, NoWord);
    add_row(8'h03, ROW_PREDICT, NoWord);
    add_row(frc_pkg::MaxLenByte + 8'd1, ROW_QUIET, NoWord);
    add_row(frc_pkg::MarkerReset, ROW_PREDICT, NoWord);
    add_row(8'h00, ROW_PREDICT, NoWord);
    add_row(8'h00, ROW_PREDICT, NoWord);
    add_row(8'h00, ROW_PREDICT, NoWord);
    add_row(8'h00, ROW_PREDICT, NoWord);
    add_row(8'h01, ROW_QUIET, NoWord);
    add_row(frc_pkg::MarkerReset, ROW_PREDICT, NoWord);
    add_row(8'h10, ROW_PREDICT, NoWord);
    add_row(8'h20, ROW_PREDICT, NoWord);
    add_row(8'hFF, ROW_PREDICT, NoWord);
    add_row(8'h02, ROW_PREDICT, NoWord);
    add_row(8'hB5, ROW_PREDICT, NoWord);
    add_row(frc_pkg::MarkerReset, ROW_PREDICT, NoWord);
    add_row(8'hFF, ROW_PREDICT, NoWord);
    foreach (directed_rows[i])
      send_byte(directed_rows[i].rx, directed_rows[i].kind, directed_rows[i].word);

    // Random phases, each under its own start marker
    markers[0] = 8'h00;
    markers[1] = 8'hFF;
    markers[2] = 8'($urandom);
    markers[3] = frc_pkg::MarkerReset;
    foreach (markers[p]) begin
      settle();
      write_marker(markers[p]);
      if (p == 2) begin
        // Stall the result side while 16-byte frames keep coming; start sending
        // only once the hold-off is under way
        hold_request = 1'b1;
        wait (hold_request == 1'b0);
        sender_tight = 1'b1;
        repeat (4) send_frame(FR_GOOD, 16);
        sender_tight = 1'b0;
      end
      random_traffic(bytes_taken + PhaseBytes);
    end

    // Drain what is still due, then watch for strays
    @(negedge clk_i);
    rx_if.valid <= 1'b0;
    drain_cycles = 0;
    while (frame_words_due.size() != 0 && drain_cycles < DrainLimit) begin
      @(posedge clk_i);
      drain_cycles++;
    end
    if (frame_words_due.size() != 0)
      report_mismatch($sformatf("%0d words never arrived", frame_words_due.size()));
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("frame_receiver_with_checksum_core regression: pass");
    end else begin
      $display("frame_receiver_with_checksum_core regression: fail");
    end
    $finish;
  end

endmodule
